// ----- rtl/imu_bias_calibrate_kalman_assert.svh -----
// Assertion macros for the IMU bias calibration block.
// Used by the port checker; needs clk_i and rst_ni in scope.
`ifndef IMU_BIAS_CALIBRATE_KALMAN_ASSERT_SVH
`define IMU_BIAS_CALIBRATE_KALMAN_ASSERT_SVH

// Implication checked on every rising edge outside reset
`define IBK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold on a rising edge outside reset
`define IBK_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/imu_cal_pkg.sv -----
// Shared types and constants for the IMU bias calibration block.
// No dependencies.
`timescale 1ns / 1ps

package imu_cal_pkg;

  localparam int NCH      = 10;
  localparam int CH_W     = 4;
  localparam int FRAC_DEF = 16;
  localparam int CNT_DEF  = 16;

  // Register indexes
  localparam logic [1:0] REG_CALIB = 2'd0;
  localparam logic [1:0] REG_QNOISE = 2'd1;
  localparam logic [1:0] REG_RNOISE = 2'd2;

  localparam logic [15:0] CALIB_RST = 16'd100;
  localparam logic [31:0] QNOISE_RST = 32'd655;
  localparam logic [31:0] RNOISE_RST = 32'd6554;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_OFF,
    ST_GAIN,
    ST_DIV_GAIN,
    ST_MUL,
    ST_EST,
    ST_COV,
    ST_DONE
  } state_e;

  // Saturate a sign-extended value to 32 bits signed
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/imu_bias_calibrate_kalman.sv -----
// Top level of the IMU bias calibration and Kalman smoothing block.
// Depends on imu_cal_pkg.
`timescale 1ns / 1ps

// One transfer in carries a ten-channel sample; one transfer out carries the
// ten smoothed channels and the calibrating flag. All divisions share one
// restoring divider that yields one quotient bit a cycle for an NW-bit dividend,
// NW = max(32+COUNT_WIDTH, 32+FRAC_BITS), and one multiplier serves the
// channel updates and the covariance update. A calibrating sample is worked
// as, per channel, an add and a division for the offset, then a division for
// the gain, a multiply and an estimate update per channel, the covariance
// update and the output load. Any other sample skips the offset steps, and
// also the gain division when the gain denominator is zero. The input is not
// ready while a sample is in work and is ready again in the cycle the result
// appears; a finished result waits in the output register while the next
// sample enters, and a result still waiting there holds the block at the end
// of that sample.
module imu_bias_calibrate_kalman
  import imu_cal_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_DEF,
  parameter int COUNT_WIDTH = CNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // orient_x,y,z,w, gyro_x,y,z, accel_x,y,z, 32 bits each from bit 0
  input  logic [319:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // filt_orient_x,y,z,w, filt_gyro_x,y,z, filt_accel_x,y,z, 32 bits each
  output logic [319:0] m_axis_tdata,
  // calibrating
  output logic         m_axis_tuser
);

  localparam int SW   = 32 + COUNT_WIDTH;
  localparam int NW   = (SW > 32 + FRAC_BITS) ? SW : 32 + FRAC_BITS;
  localparam int CNTW = $clog2(NW + 1);
  localparam int GW   = FRAC_BITS + 1;
  localparam int BW   = FRAC_BITS + 2;
  localparam int PW   = 33 + BW;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [BW-1:0] ONE_FX = BW'(1) << FRAC_BITS;

  state_e state_q, state_d;

  logic [15:0] calib_q;
  logic [31:0] qn_q, rn_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic signed [SW-1:0] sums_q [NCH];
  logic [31:0] off_q [NCH];
  logic [31:0] est_q [NCH];
  logic [31:0] meas_q [NCH];
  logic [31:0] cov_q;
  logic [CH_W-1:0] ch_q;
  logic calib_q_flag;
  logic [31:0] ppred_q;
  logic [GW-1:0] gain_q;
  logic signed [PW-1:0] prod_q;
  logic sign_q;
  logic out_valid_q;
  logic out_calib_q;
  logic [319:0] out_data_q;

  // divider state
  logic [NW-1:0] dvd_q;
  logic [32:0] rem_q, dvs_q;
  logic [CNTW-1:0] cnt_q;

  logic accept, last_ch, div_done, calib_now;
  logic signed [SW-1:0] sum_new, sum_abs;
  logic [32:0] ppred_w, denom;
  logic [31:0] ppred;
  logic [33:0] rem_sh;
  logic div_ge;
  logic [32:0] rem_nx;
  logic [NW:0] neg_q;
  logic [31:0] corr, est_new, off_new;
  logic signed [32:0] diff;
  logic signed [32:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [63:0] step64;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign last_ch   = (ch_q == CH_W'(NCH - 1));
  assign div_done  = (cnt_q == '0);
  assign calib_now = ({16'd0, count_q} < {{COUNT_WIDTH{1'b0}}, calib_q})
                     && (count_q != CNT_MAX);

  // running sum and its magnitude for the offset division
  assign sum_new = sums_q[ch_q] + {{(SW-32){meas_q[ch_q][31]}}, meas_q[ch_q]};
  assign sum_abs = sum_new[SW-1] ? -sum_new : sum_new;

  // predicted covariance and gain denominator
  assign ppred_w = {1'b0, cov_q} + {1'b0, qn_q};
  assign ppred   = ppred_w[32] ? 32'hFFFF_FFFF : ppred_w[31:0];
  assign denom   = {1'b0, ppred} + {1'b0, rn_q};

  // one restoring step of the shared divider
  assign rem_sh = {rem_q, dvd_q[NW-1]};
  assign div_ge = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = div_ge ? 33'(rem_sh - {1'b0, dvs_q}) : rem_sh[32:0];

  // offset is the negated truncated mean
  assign neg_q   = sign_q ? {1'b0, dvd_q} : -{1'b0, dvd_q};
  assign off_new = sat32({{(63-NW){neg_q[NW]}}, neg_q});

  // corrected sample and innovation
  assign corr = sat32({{32{meas_q[ch_q][31]}}, meas_q[ch_q]}
                      + {{32{off_q[ch_q][31]}}, off_q[ch_q]});
  assign diff = {corr[31], corr} - {est_q[ch_q][31], est_q[ch_q]};

  // shared multiplier operands
  always_comb begin
    if (state_q == ST_COV) begin
      mul_a = {1'b0, ppred_q};
      mul_b = ONE_FX - {1'b0, gain_q};
    end else begin
      mul_a = diff;
      mul_b = {1'b0, gain_q};
    end
  end
  assign prod = PW'(mul_a) * PW'(mul_b);

  assign step64  = $signed({{(64-PW){prod_q[PW-1]}}, prod_q}) >>> FRAC_BITS;
  assign est_new = sat32(step64 + {{32{est_q[ch_q][31]}}, est_q[ch_q]});

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_calib_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (accept) state_d = calib_now ? ST_SUM : ST_GAIN;
      ST_SUM:      state_d = ST_DIV_OFF;
      ST_DIV_OFF:  if (div_done) state_d = last_ch ? ST_GAIN : ST_SUM;
      ST_GAIN:     state_d = (denom == '0) ? ST_MUL : ST_DIV_GAIN;
      ST_DIV_GAIN: if (div_done) state_d = ST_MUL;
      ST_MUL:      state_d = ST_EST;
      ST_EST:      state_d = last_ch ? ST_COV : ST_MUL;
      ST_COV:      state_d = ST_DONE;
      ST_DONE:     if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q <= CALIB_RST;
      qn_q    <= QNOISE_RST;
      rn_q    <= RNOISE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CALIB:  calib_q <= cfg_data_i[15:0];
        REG_QNOISE: qn_q <= cfg_data_i;
        REG_RNOISE: rn_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output register: drop on transfer, load when the sample is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
      out_calib_q <= calib_q_flag;
      for (int i = 0; i < NCH; i++) out_data_q[32*i +: 32] <= est_q[i];
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cov_q   <= 32'(64'd1 << FRAC_BITS);
      for (int i = 0; i < NCH; i++) begin
        sums_q[i] <= '0;
        off_q[i]  <= '0;
        est_q[i]  <= '0;
      end
    end else begin
      if (accept && calib_now) count_q <= count_q + 1'b1;
      if (state_q == ST_SUM) sums_q[ch_q] <= sum_new;
      if (state_q == ST_DIV_OFF && div_done) off_q[ch_q] <= off_new;
      if (state_q == ST_EST) est_q[ch_q] <= est_new;
      if (state_q == ST_DONE && (!out_valid_q || m_axis_tready))
        cov_q <= prod_q[FRAC_BITS +: 32];
    end
  end

  // working registers and the shared divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ch_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: ch_q <= '0;
        ST_SUM: cnt_q <= CNTW'(NW);
        ST_DIV_OFF: begin
          if (!div_done) cnt_q <= cnt_q - 1'b1;
          else ch_q <= last_ch ? '0 : ch_q + 1'b1;
        end
        ST_GAIN: if (denom != '0) cnt_q <= CNTW'(NW);
        ST_DIV_GAIN: if (!div_done) cnt_q <= cnt_q - 1'b1;
        ST_EST: ch_q <= last_ch ? '0 : ch_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          calib_q_flag <= calib_now;
          for (int i = 0; i < NCH; i++) meas_q[i] <= s_axis_tdata[32*i +: 32];
        end
      end
      ST_SUM: begin
        sign_q <= sum_new[SW-1];
        dvd_q  <= NW'(unsigned'(sum_abs));
        dvs_q  <= 33'(count_q);
        rem_q  <= '0;
      end
      ST_GAIN: begin
        ppred_q <= ppred;
        gain_q  <= '0;
        dvd_q   <= NW'({ppred, {FRAC_BITS{1'b0}}});
        dvs_q   <= denom;
        rem_q   <= '0;
      end
      ST_DIV_OFF, ST_DIV_GAIN: begin
        if (!div_done) begin
          rem_q <= rem_nx;
          dvd_q <= {dvd_q[NW-2:0], div_ge};
        end else if (state_q == ST_DIV_GAIN) begin
          gain_q <= dvd_q[GW-1:0];
        end
      end
      ST_MUL, ST_COV: prod_q <= prod;
      default: ;
    endcase
  end

endmodule

// ----- rtl/imu_cal_chk.sv -----
// Port checker for the IMU bias calibration block, bound to its top level.
// Depends on imu_bias_calibrate_kalman_assert.svh.
`timescale 1ns / 1ps
`include "imu_bias_calibrate_kalman_assert.svh"

module imu_cal_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [319:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // a sample in work blocks the next one
  `IBK_ASSERT(busy_after_in, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "ready after transfer")
  // no result appears the cycle after a sample enters an empty output
  `IBK_ASSERT(no_instant_out, (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid, "result too early")
  // a stalled result holds
  `IBK_ASSERT(out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")
  // an offered result is fully known
  `IBK_NEVER(out_known, m_axis_tvalid && $isunknown({m_axis_tdata, m_axis_tuser}), "unknown result")

endmodule

bind imu_bias_calibrate_kalman imu_cal_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for imu_bias_calibrate_kalman: streams IMU samples,
// predicts bias removal and Kalman smoothing per channel, checks every result.
// Depends on imu_cal_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import imu_cal_pkg::*;

  typedef logic signed [31:0] fx_t;
  typedef struct packed {
    logic [319:0] chans;
    logic         calib;
  } filt_t;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned COUNT_LIMIT = 65535;
  localparam int unsigned ONE_Q = 65536;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [319:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [319:0] m_axis_tdata;
  logic         m_axis_tuser;

  imu_bias_calibrate_kalman dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Filter state mirrored from the block
  int unsigned   calib_limit = 100;
  longint        q_noise = 655;
  longint        r_noise = 6554;
  int unsigned   samples_seen = 0;
  longint        bias_sum[NCH];
  fx_t           bias_off[NCH];
  fx_t           smooth_est[NCH];
  longint        shared_cov = ONE_Q;

  filt_t         filt_pending[$];
  int            errors = 0;
  int            n_sent = 0;
  int            n_checked = 0;
  int            n_calib = 0;
  int            burst_left = 0;
  int            stall_pct = 0;
  int            hold_req = 0;
  int            hold_cnt = 0;
  int            idle_cycles = 0;
  fx_t           sensor_bias[NCH];

  function automatic fx_t clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return fx_t'(v[31:0]);
  endfunction

  // Advance the mirrored state by one sample and return the filtered result
  function automatic filt_t smooth_sample(input fx_t s[NCH]);
    filt_t  r;
    longint pp, den, k, corr, diff, stp, q;
    r.calib = (samples_seen < calib_limit) && (samples_seen < COUNT_LIMIT);
    if (r.calib) begin
      samples_seen++;
      for (int i = 0; i < NCH; i++) begin
        bias_sum[i] += longint'(s[i]);
        q = bias_sum[i] / longint'(samples_seen);
        bias_off[i] = clip32(-q);
      end
    end
    pp = shared_cov + q_noise;
    if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
    den = pp + r_noise;
    k = (den == 0) ? 0 : (pp <<< 16) / den;
    for (int i = 0; i < NCH; i++) begin
      corr = longint'(clip32(longint'(s[i]) + longint'(bias_off[i])));
      diff = corr - longint'(smooth_est[i]);
      stp = (diff * k) >>> 16;
      smooth_est[i] = clip32(longint'(smooth_est[i]) + stp);
      r.chans[32*i +: 32] = smooth_est[i];
    end
    shared_cov = (((longint'(ONE_Q) - k) * pp) >>> 16) & 64'hFFFF_FFFF;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    $display("mismatch at result %0d: %s expected %h got %h", n_checked, what, want, got);
  endtask

  // Send one sample; the sender works in bursts with random gaps
  task automatic send_sample(input fx_t s[NCH]);
    for (int i = 0; i < NCH; i++) s_axis_tdata[32*i +: 32] <= s[i];
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    filt_pending.push_back(smooth_sample(s));
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Hold the sender until every expected result has come, then let the block settle
  task automatic drain;
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (filt_pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Write a register once nothing is in flight
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (filt_pending.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_CALIB:  calib_limit = val[15:0];
      REG_QNOISE: q_noise = val;
      REG_RNOISE: r_noise = val;
      default: ;
    endcase
  endtask

  task automatic send_flat(input fx_t v);
    fx_t s[NCH];
    foreach (s[i]) s[i] = v;
    send_sample(s);
  endtask

  // Mostly a steady sensor with noise around a bias, some full-range noise and extremes
  task automatic send_random;
    fx_t s[NCH];
    int  m;
    m = $urandom_range(0, 99);
    foreach (s[i]) begin
      if (m < 80) s[i] = sensor_bias[i] + fx_t'($urandom_range(0, 4000)) - 2000;
      else if (m < 95) s[i] = fx_t'($urandom);
      else
        case ($urandom_range(0, 3))
          0: s[i] = 32'sh8000_0000;
          1: s[i] = 32'sh7FFF_FFFF;
          2: s[i] = 0;
          default: s[i] = -1;
        endcase
    end
    send_sample(s);
  endtask

  task automatic new_sensor_bias;
    foreach (sensor_bias[i]) sensor_bias[i] = fx_t'($urandom) >>> $urandom_range(0, 20);
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    filt_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (filt_pending.size() == 0) begin
        errors++;
        $display("unexpected result with nothing pending");
      end else begin
        want = filt_pending.pop_front();
        for (int i = 0; i < NCH; i++)
          if (m_axis_tdata[32*i +: 32] !== want.chans[32*i +: 32])
            report_mismatch($sformatf("channel %0d", i), want.chans[32*i +: 32],
                            m_axis_tdata[32*i +: 32]);
        if (m_axis_tuser !== want.calib)
          report_mismatch("calibrating", 32'(want.calib), 32'(m_axis_tuser));
        if (want.calib) n_calib++;
      end
      n_checked++;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL imu_bias_calibrate_kalman");
      $finish;
    end
  end

  task automatic test_reset_values;
    new_sensor_bias();
    repeat (3) send_random();
    drain();
  endtask

  // Most negative value into the offset mean, then input plus offset overflowing
  task automatic test_offset_saturation;
    cfg_write(REG_CALIB, 32'd4);
    send_flat(32'sh8000_0000);
    send_flat(32'sh8000_0000);
    cfg_write(REG_CALIB, 32'd0);
    send_flat(32'sh7FFF_FFFF);
    send_flat(32'sh8000_0000);
    send_flat(0);
    send_flat(-1);
    drain();
  endtask

  // Zero noise drives the covariance to zero and the gain denominator with it
  task automatic test_zero_denominator;
    cfg_write(REG_QNOISE, 32'd0);
    cfg_write(REG_RNOISE, 32'd0);
    send_flat(32'sh0001_0000);
    send_flat(32'sh7FFF_FFFF);
    send_flat(-5);
    drain();
    cfg_write(REG_QNOISE, 32'hFFFF_FFFF);
    send_flat(32'sh1234_5678);
    cfg_write(REG_RNOISE, 32'hFFFF_FFFF);
    send_flat(32'sh8000_0000);
    send_flat(32'sh7FFF_FFFF);
    cfg_write(REG_QNOISE, 32'd0);
    send_flat(1);
    drain();
  endtask

  // Resume after raising the window, lower it, widest window, stray index
  task automatic test_calib_window;
    cfg_write(REG_QNOISE, 32'd655);
    cfg_write(REG_RNOISE, 32'd6554);
    cfg_write(REG_CALIB, 32'd6);
    repeat (3) send_random();
    drain();
    cfg_write(REG_CALIB, 32'd1);
    send_random();
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_write(REG_CALIB, 32'hFFFF_FFFF);
    repeat (3) send_random();
    drain();
  endtask

  task automatic test_random_defaults;
    cfg_write(REG_CALIB, 32'd100);
    new_sensor_bias();
    stall_pct = 0;
    repeat (400) send_random();
    drain();
  endtask

  // Long receiver hold-off while the sender keeps offering samples
  task automatic test_random_backpressure;
    stall_pct = 30;
    repeat (150) send_random();
    hold_req = 3000;
    repeat (220) send_random();
    drain();
  endtask

  task automatic test_random_settings;
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(REG_QNOISE, $urandom >> $urandom_range(0, 31));
      cfg_write(REG_RNOISE, $urandom >> $urandom_range(0, 31));
      cfg_write(REG_CALIB, $urandom_range(0, samples_seen + 30));
      new_sensor_bias();
      stall_pct = $urandom_range(0, 60);
      repeat (100) send_random();
      drain();
    end
  endtask

  initial begin
    foreach (bias_sum[i]) begin
      bias_sum[i] = 0;
      bias_off[i] = 0;
      smooth_est[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_offset_saturation();
    test_zero_denominator();
    test_calib_window();
    test_random_defaults();
    test_random_backpressure();
    test_random_settings();
    $display("Sent %0d samples, checked %0d results, %0d of them calibrating.",
             n_sent, n_checked, n_calib);
    $display("Covered saturation, zero gain, noise extremes, window changes and stalls.");
    if (errors == 0) begin
      $display("PASS imu_bias_calibrate_kalman");
    end else begin
      $display("FAIL imu_bias_calibrate_kalman");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/imu_cal_pkg.sv
rtl/imu_bias_calibrate_kalman.sv
rtl/imu_cal_chk.sv
dv/tb_top.sv
